FILE: rtl/core/sm3_pkg.sv
package sm3_pkg;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PAD,
      ST_COMP,
      ST_FOLD,
      ST_OUT
   } state_type;

   localparam int BLOCK_WORDS  = 16;
   localparam int ROUNDS       = 64;
   localparam int DIGEST_WORDS = 8;

   localparam logic [31:0] SM3_IV [DIGEST_WORDS] = '{
      32'h7380_166F, 32'h4914_B2B9, 32'h1724_42D7, 32'hDA8A_0600,
      32'hA96F_30BC, 32'h1631_38AA, 32'hE38D_EE4D, 32'hB0FB_0E4E
   };

   localparam logic [31:0] TJ_LOW   = 32'h79CC_4519;
   localparam logic [31:0] TJ_HIGH  = 32'h7A87_9D8A;
   localparam logic [7:0]  PAD_BYTE = 8'h80;

   function automatic logic [31:0] rotl(input logic [31:0] x, input logic [4:0] n);
      logic [63:0] t;
      t = {x, x} << n;
      return t[63:32];
   endfunction

   function automatic logic [31:0] perm0(input logic [31:0] x);
      return x ^ rotl(x, 5'd9) ^ rotl(x, 5'd17);
   endfunction

   function automatic logic [31:0] perm1(input logic [31:0] x);
      return x ^ rotl(x, 5'd15) ^ rotl(x, 5'd23);
   endfunction

endpackage

FILE: rtl/core/sm3_if.sv
interface sm3_req_if;
   logic        valid;
   logic        ready;
   logic [31:0] data;
   logic [2:0]  nbytes;
   logic        last;

   modport source (output valid, output data, output nbytes, output last, input ready);
   modport sink   (input valid, input data, input nbytes, input last, output ready);
endinterface

interface sm3_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] digest_word;
   logic [2:0]  word_index;
   logic        last_res;

   modport source (output valid, output digest_word, output word_index, output last_res,
                   input ready);
   modport sink   (input valid, input digest_word, input word_index, input last_res,
                   output ready);
endinterface

FILE: rtl/core/sm3_hash_engine.sv
// SM3 hash engine.
// req_ch takes the message as big-endian 32-bit words (first byte in bits 31..24).
// Every word carries four bytes except the one marked last, whose nbytes (0..4,
// larger counts read as 4) gives its valid leading bytes.
// Sixteen words make a block. The 16th word starts a compression: 64 rounds at
// one round per cycle on a single shared round unit, then a fold of the result
// into the chaining value. req_ch.ready is low while a block is compressed.
// After the last word the sequencer writes the padding words (0x80 if still
// owed, zeros, the 64-bit bit length) one per cycle and compresses one or two
// more blocks; then rsp_ch presents the eight digest words, index 0 first,
// last_res on index 7. How soon digest word 0 follows the last word depends on
// how many padding words remain and whether a second padding block is needed.
// A stalled receiver simply holds the current digest word; no new word is taken
// until all eight digest words are delivered, after which a new message begins.
// Reset (synchronous) loads the initial vector and starts an empty message.
module sm3_hash_engine (
   input logic        clock,
   input logic        reset,
   sm3_req_if.sink    req_ch,
   sm3_rsp_if.source  rsp_ch
);
   import sm3_pkg::*;

   state_type   state_ff, state_in;
   logic [3:0]  fill_ff, fill_in;          // words in the block buffer
   logic [63:0] bits_ff, bits_in;          // message length in bits
   logic        owed_ff, owed_in;          // 0x80 still to be placed
   logic        final_ff, final_in;        // padding in progress
   logic        len_hi_ff, len_hi_in;      // high length word written
   logic        len_done_ff, len_done_in;  // low length word written
   logic [5:0]  round_ff, round_in;
   logic [2:0]  out_idx_ff, out_idx_in;
   logic [31:0] chain_ff [DIGEST_WORDS];
   logic [31:0] vars_ff  [DIGEST_WORDS];
   // block buffer, reused as the sliding expansion window during the rounds
   logic [31:0] wnd_ff   [BLOCK_WORDS];

   logic        req_take, rsp_take;
   logic        wr_en;
   logic [31:0] wr_word;
   logic        blk_start;
   logic [2:0]  nb_eff;
   logic [31:0] keep_mask, pad_word;

   // round unit
   logic [31:0] tj, a12, ss1, ss2, ffv, ggv, tt1, tt2, w_new;

   assign req_take  = req_ch.valid && req_ch.ready;
   assign rsp_take  = rsp_ch.valid && rsp_ch.ready;
   assign blk_start = wr_en && (fill_ff == 4'(BLOCK_WORDS - 1));

   always_comb begin
      tj  = (round_ff[5:4] == 2'd0) ? TJ_LOW : TJ_HIGH;
      a12 = rotl(vars_ff[0], 5'd12);
      ss1 = rotl(a12 + vars_ff[4] + rotl(tj, round_ff[4:0]), 5'd7);
      ss2 = ss1 ^ a12;
      if (round_ff[5:4] == 2'd0) begin
         ffv = vars_ff[0] ^ vars_ff[1] ^ vars_ff[2];
         ggv = vars_ff[4] ^ vars_ff[5] ^ vars_ff[6];
      end else begin
         ffv = (vars_ff[0] & vars_ff[1]) | (vars_ff[0] & vars_ff[2])
             | (vars_ff[1] & vars_ff[2]);
         ggv = (vars_ff[4] & vars_ff[5]) | (~vars_ff[4] & vars_ff[6]);
      end
      tt1   = ffv + vars_ff[3] + ss2 + (wnd_ff[0] ^ wnd_ff[4]);
      tt2   = ggv + vars_ff[7] + ss1 + wnd_ff[0];
      w_new = perm1(wnd_ff[0] ^ wnd_ff[7] ^ rotl(wnd_ff[13], 5'd15))
            ^ rotl(wnd_ff[3], 5'd7) ^ wnd_ff[10];
   end

   // final partial word: keep nb leading bytes, place 0x80 right after them if nb < 4
   always_comb begin
      nb_eff    = (req_ch.nbytes > 3'd4) ? 3'd4 : req_ch.nbytes;
      keep_mask = ~(32'hFFFF_FFFF >> {nb_eff, 3'b000});
      pad_word  = {PAD_BYTE, 24'd0} >> {nb_eff, 3'b000};
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               if (blk_start)          state_in = ST_COMP;
               else if (req_ch.last)   state_in = ST_PAD;
            end
         end
         ST_PAD: begin
            if (blk_start) state_in = ST_COMP;
         end
         ST_COMP: begin
            if (round_ff == 6'(ROUNDS - 1)) state_in = ST_FOLD;
         end
         ST_FOLD: begin
            if (len_done_ff)   state_in = ST_OUT;
            else if (final_ff) state_in = ST_PAD;
            else               state_in = ST_IDLE;
         end
         ST_OUT: begin
            if (rsp_take && out_idx_ff == 3'(DIGEST_WORDS - 1)) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // sequencer outputs and control updates
   always_comb begin
      wr_en       = 1'b0;
      wr_word     = '0;
      owed_in     = owed_ff;
      final_in    = final_ff;
      len_hi_in   = len_hi_ff;
      len_done_in = len_done_ff;
      bits_in     = bits_ff;
      round_in    = round_ff;
      out_idx_in  = out_idx_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               wr_en = 1'b1;
               if (!req_ch.last) begin
                  wr_word = req_ch.data;
                  bits_in = bits_ff + 64'd32;
               end else begin
                  wr_word  = (req_ch.data & keep_mask) | pad_word;
                  bits_in  = bits_ff + {58'd0, nb_eff, 3'b000};
                  final_in = 1'b1;
                  owed_in  = (nb_eff == 3'd4);
               end
            end
         end
         ST_PAD: begin
            wr_en = 1'b1;
            if (owed_ff) begin
               wr_word = {PAD_BYTE, 24'd0};
               owed_in = 1'b0;
            end else if (len_hi_ff) begin
               wr_word     = bits_ff[31:0];
               len_hi_in   = 1'b0;
               len_done_in = 1'b1;
            end else if (fill_ff == 4'(BLOCK_WORDS - 2)) begin
               wr_word   = bits_ff[63:32];
               len_hi_in = 1'b1;
            end
         end
         ST_COMP: begin
            round_in = round_ff + 6'd1;
         end
         ST_OUT: begin
            if (rsp_take) begin
               out_idx_in = out_idx_ff + 3'd1;
               if (out_idx_ff == 3'(DIGEST_WORDS - 1)) begin
                  bits_in     = '0;
                  final_in    = 1'b0;
                  len_done_in = 1'b0;
               end
            end
         end
         default: ;
      endcase
      if (blk_start) round_in = '0;
   end

   assign fill_in = wr_en ? fill_ff + 4'd1 : fill_ff;

   always_comb begin
      req_ch.ready       = (state_ff == ST_IDLE);
      rsp_ch.valid       = (state_ff == ST_OUT);
      rsp_ch.digest_word = chain_ff[out_idx_ff];
      rsp_ch.word_index  = out_idx_ff;
      rsp_ch.last_res    = (out_idx_ff == 3'(DIGEST_WORDS - 1));
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= ST_IDLE;
         fill_ff     <= '0;
         bits_ff     <= '0;
         owed_ff     <= 1'b0;
         final_ff    <= 1'b0;
         len_hi_ff   <= 1'b0;
         len_done_ff <= 1'b0;
         round_ff    <= '0;
         out_idx_ff  <= '0;
      end else begin
         state_ff    <= state_in;
         fill_ff     <= fill_in;
         bits_ff     <= bits_in;
         owed_ff     <= owed_in;
         final_ff    <= final_in;
         len_hi_ff   <= len_hi_in;
         len_done_ff <= len_done_in;
         round_ff    <= round_in;
         out_idx_ff  <= out_idx_in;
      end
   end

   // chaining value
   always_ff @(posedge clock) begin
      if (reset) begin
         chain_ff <= SM3_IV;
      end else if (state_ff == ST_FOLD) begin
         for (int i = 0; i < DIGEST_WORDS; i++) chain_ff[i] <= chain_ff[i] ^ vars_ff[i];
      end else if (rsp_take && out_idx_ff == 3'(DIGEST_WORDS - 1)) begin
         chain_ff <= SM3_IV;
      end
   end

   // working registers A..H
   always_ff @(posedge clock) begin
      if (blk_start) begin
         vars_ff <= chain_ff;
      end else if (state_ff == ST_COMP) begin
         vars_ff[0] <= tt1;
         vars_ff[1] <= vars_ff[0];
         vars_ff[2] <= rotl(vars_ff[1], 5'd9);
         vars_ff[3] <= vars_ff[2];
         vars_ff[4] <= perm0(tt2);
         vars_ff[5] <= vars_ff[4];
         vars_ff[6] <= rotl(vars_ff[5], 5'd19);
         vars_ff[7] <= vars_ff[6];
      end
   end

   // block buffer / expansion window
   always_ff @(posedge clock) begin
      if (wr_en) begin
         wnd_ff[fill_ff] <= wr_word;
      end else if (state_ff == ST_COMP) begin
         for (int i = 0; i < BLOCK_WORDS - 1; i++) wnd_ff[i] <= wnd_ff[i + 1];
         wnd_ff[BLOCK_WORDS - 1] <= w_new;
      end
   end

endmodule

FILE: rtl/core/sm3_hash_checker.sv
module sm3_hash_checker (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input logic       req_last,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input logic [2:0] word_index,
   input logic       last_res
);

   // never takes a word while a digest is on offer
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("input ready while digest pending");

   a_last_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (last_res == (word_index == 3'd7)))
      else $error("last_res does not match word_index");

   a_index_step: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && !last_res) |=>
         (rsp_valid && word_index == $past(word_index) + 3'd1))
      else $error("digest words not consecutive");

   a_digest_end: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_ready && last_res) |=> (!rsp_valid && word_index == 3'd0))
      else $error("digest continues past eighth word");

   a_no_early_digest: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && !req_last) |=> !rsp_valid)
      else $error("digest after a non-final word");

endmodule

bind sm3_hash_engine sm3_hash_checker u_sm3_chk (
   .clock      (clock),
   .reset      (reset),
   .req_valid  (req_ch.valid),
   .req_ready  (req_ch.ready),
   .req_last   (req_ch.last),
   .rsp_valid  (rsp_ch.valid),
   .rsp_ready  (rsp_ch.ready),
   .word_index (rsp_ch.word_index),
   .last_res   (rsp_ch.last_res)
);

FILE: tb/tb.sv
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   import sm3_pkg::*;

   // Watchdog: cycles with no word moving on either channel. The slowest
   // correct gap is the long receiver hold plus the worst padding latency,
   // so this leaves ample margin.
   localparam int QUIET_LIMIT = 5000;
   localparam int HOLD_CYCLES = 400;
   localparam int DRAIN_CYCLES = 160;   // longer than the worst last-word-to-digest latency

   typedef struct packed {
      logic [31:0] data;
      logic [2:0]  nbytes;
      logic        last;
   } msg_word_type;

   typedef struct packed {
      logic [31:0] digest_word;
      logic [2:0]  word_index;
      logic        last_res;
   } digest_type;

   typedef enum int {FILL_RANDOM, FILL_ZERO, FILL_ONES} fill_kind_type;

   logic clock;
   logic reset;

   sm3_req_if req_ch ();
   sm3_rsp_if rsp_ch ();

   sm3_hash_engine i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   // ---------------------------------------------------------------------------
   // Hash model: chaining value, block being filled, byte count, bit length.
   // ---------------------------------------------------------------------------
   logic [31:0] chain_h [8];
   logic [31:0] block_w [16];
   int          block_bytes;
   logic [63:0] length_bits;

   msg_word_type words_to_send [$];   // message words not yet put on the bus
   digest_type   digest_due    [$];   // digest words still owed by the block

   int errors;

   // idle / stall controls, set per phase by the stimulus thread
   int  send_idle_pct;
   int  rsp_stall_pct;
   bit  hold_req;

   function automatic logic [31:0] rol32(input logic [31:0] x, input int n);
      int s;
      s = n % 32;
      if (s == 0)
         return x;
      return (x << s) | (x >> (32 - s));
   endfunction

   function automatic logic [31:0] mix_p0(input logic [31:0] x);
      return x ^ rol32(x, 9) ^ rol32(x, 17);
   endfunction

   function automatic logic [31:0] mix_p1(input logic [31:0] x);
      return x ^ rol32(x, 15) ^ rol32(x, 23);
   endfunction

   // One SM3 compression of block_w into chain_h.
   task automatic compress_block();
      logic [31:0] w [68];
      logic [31:0] wp [64];
      logic [31:0] v [8];
      logic [31:0] a12, ss1, ss2, tt1, tt2, ff, gg, tj;
      for (int j = 0; j < 16; j++)
         w[j] = block_w[j];
      for (int j = 16; j < 68; j++)
         w[j] = mix_p1(w[j-16] ^ w[j-9] ^ rol32(w[j-3], 15)) ^ rol32(w[j-13], 7) ^ w[j-6];
      for (int j = 0; j < 64; j++)
         wp[j] = w[j] ^ w[j+4];
      for (int i = 0; i < 8; i++)
         v[i] = chain_h[i];
      for (int j = 0; j < ROUNDS; j++) begin
         tj  = (j < 16) ? TJ_LOW : TJ_HIGH;
         a12 = rol32(v[0], 12);
         ss1 = rol32(a12 + v[4] + rol32(tj, j), 7);
         ss2 = ss1 ^ a12;
         if (j < 16) begin
            ff = v[0] ^ v[1] ^ v[2];
            gg = v[4] ^ v[5] ^ v[6];
         end else begin
            ff = (v[0] & v[1]) | (v[0] & v[2]) | (v[1] & v[2]);
            gg = (v[4] & v[5]) | (~v[4] & v[6]);
         end
         tt1 = ff + v[3] + ss2 + wp[j];
         tt2 = gg + v[7] + ss1 + w[j];
         v[3] = v[2];
         v[2] = rol32(v[1], 9);
         v[1] = v[0];
         v[0] = tt1;
         v[7] = v[6];
         v[6] = rol32(v[5], 19);
         v[5] = v[4];
         v[4] = mix_p0(tt2);
      end
      for (int i = 0; i < 8; i++)
         chain_h[i] = chain_h[i] ^ v[i];
   endtask

   task automatic add_byte(input logic [7:0] b);
      int idx;
      int sh;
      idx = block_bytes / 4;
      sh  = (3 - block_bytes % 4) * 8;
      if (block_bytes % 4 == 0)
         block_w[idx] = 32'(b) << sh;
      else
         block_w[idx] = block_w[idx] | (32'(b) << sh);
      block_bytes = (block_bytes + 1) % 64;
      if (block_bytes == 0)
         compress_block();
   endtask

   // Take one accepted word; on the final word pad, finish and queue the digest.
   task automatic absorb_word(input logic [31:0] d, input logic [2:0] nb, input logic fin);
      int          cnt;
      logic [63:0] len;
      digest_type  dw;
      // only the final word may be short; oversized counts read as four bytes
      cnt = (!fin || nb > 3'd4) ? 4 : int'(nb);
      for (int k = 0; k < cnt; k++)
         add_byte(d[31 - 8*k -: 8]);
      length_bits = length_bits + 64'(cnt * 8);
      if (!fin)
         return;
      len = length_bits;
      add_byte(PAD_BYTE);
      while (block_bytes != 56)
         add_byte(8'h00);
      for (int k = 0; k < 8; k++)
         add_byte(len[63 - 8*k -: 8]);
      for (int k = 0; k < DIGEST_WORDS; k++) begin
         dw.digest_word = chain_h[k];
         dw.word_index  = 3'(k);
         dw.last_res    = (k == DIGEST_WORDS - 1);
         digest_due.push_back(dw);
      end
      // fresh message state
      for (int i = 0; i < 8; i++)
         chain_h[i] = SM3_IV[i];
      block_bytes = 0;
      length_bits = '0;
   endtask

   // ---------------------------------------------------------------------------
   // Clock
   // ---------------------------------------------------------------------------
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // ---------------------------------------------------------------------------
   // Driver: puts queued message words on req_ch at the falling edge.
   // A word stays up until the monitor has counted it as accepted.
   // ---------------------------------------------------------------------------
   int           words_issued;
   int           words_accepted;
   bit           drv_on;
   msg_word_type cur_word;

   always @(negedge clock) begin
      if (reset) begin
         drv_on = 1'b0;
      end else begin
         if (drv_on && words_accepted == words_issued)
            drv_on = 1'b0;
         if (!drv_on && words_to_send.size() > 0 &&
             $urandom_range(99) >= send_idle_pct) begin
            cur_word = words_to_send.pop_front();
            words_issued++;
            drv_on = 1'b1;
         end
      end
      req_ch.valid  <= drv_on;
      req_ch.data   <= cur_word.data;
      req_ch.nbytes <= cur_word.nbytes;
      req_ch.last   <= cur_word.last;
   end

   // ---------------------------------------------------------------------------
   // Receiver: random stalls, plus one long hold-off counted here so the
   // engine backs up and drops req ready while the driver keeps offering.
   // ---------------------------------------------------------------------------
   int hold_left;
   bit hold_seen;

   always @(negedge clock) begin
      logic rdy;
      if (hold_req && !hold_seen) begin
         hold_seen = 1'b1;
         hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
         hold_left--;
         rdy = 1'b0;
      end else begin
         rdy = ($urandom_range(99) >= rsp_stall_pct);
      end
      rsp_ch.ready <= rdy;
   end

   // ---------------------------------------------------------------------------
   // Monitor: sample both channels at the rising edge, run the model on every
   // accepted message word, compare every digest word with the oldest one owed.
   // ---------------------------------------------------------------------------
   int quiet;

   always @(posedge clock) begin
      digest_type got;
      digest_type want;
      bit         moved;
      if (!reset) begin
         moved = 1'b0;
         if (req_ch.valid && req_ch.ready) begin
            absorb_word(req_ch.data, req_ch.nbytes, req_ch.last);
            words_accepted++;
            moved = 1'b1;
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            moved = 1'b1;
            got.digest_word = rsp_ch.digest_word;
            got.word_index  = rsp_ch.word_index;
            got.last_res    = rsp_ch.last_res;
            if (digest_due.size() == 0) begin
               errors++;
               $display("%0t: unexpected digest word: expected none, got %h idx %0d last %0b",
                        $time, got.digest_word, got.word_index, got.last_res);
            end else begin
               want = digest_due.pop_front();
               if (got.digest_word !== want.digest_word ||
                   got.word_index  !== want.word_index  ||
                   got.last_res    !== want.last_res) begin
                  errors++;
                  $display("%0t: digest mismatch: exp %h/%0d/%0b got %h/%0d/%0b",
                           $time, want.digest_word, want.word_index, want.last_res,
                           got.digest_word, got.word_index, got.last_res);
               end
            end
         end
         quiet = moved ? 0 : quiet + 1;
         if (quiet >= QUIET_LIMIT) begin
            $display("%0t: no traffic for %0d cycles", $time, QUIET_LIMIT);
            $display("Regression FAIL");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Stimulus
   // ---------------------------------------------------------------------------

   // Queue one message: body full words, then the final word with tail_nb.
   // With odd_body set, some body words carry a short or oversized count,
   // which must still add four bytes.
   task automatic queue_msg(input int body, input logic [2:0] tail_nb,
                            input fill_kind_type kind, input bit odd_body);
      msg_word_type mw;
      for (int i = 0; i <= body; i++) begin
         case (kind)
            FILL_ZERO: mw.data = 32'h0000_0000;
            FILL_ONES: mw.data = 32'hFFFF_FFFF;
            default:   mw.data = $urandom;
         endcase
         mw.last = (i == body);
         if (mw.last)
            mw.nbytes = tail_nb;
         else if (odd_body && $urandom_range(3) == 0)
            mw.nbytes = 3'($urandom_range(7));
         else
            mw.nbytes = 3'd4;
         words_to_send.push_back(mw);
      end
   endtask

   // Random messages, mostly under two blocks, now and then up to three.
   task automatic queue_random(input int target);
      int n;
      int body;
      n = 0;
      while (n < target) begin
         body = ($urandom_range(9) == 0) ? $urandom_range(16, 40) : $urandom_range(0, 17);
         queue_msg(body, 3'($urandom_range(7)), FILL_RANDOM, 1'b1);
         n += body + 1;
      end
   endtask

   // Wait until every word is sent and every digest word is back.
   task automatic drain();
      while (words_to_send.size() > 0 || drv_on || digest_due.size() > 0)
         @(posedge clock);
   endtask

   task automatic run_phase(input int idle_pct, input int stall_pct, input int n_words);
      send_idle_pct = idle_pct;
      rsp_stall_pct = stall_pct;
      queue_random(n_words);
      drain();
   endtask

   initial begin
      reset          = 1'b1;
      req_ch.valid   = 1'b0;
      req_ch.data    = '0;
      req_ch.nbytes  = '0;
      req_ch.last    = 1'b0;
      rsp_ch.ready   = 1'b0;
      cur_word       = '0;
      words_issued   = 0;
      words_accepted = 0;
      drv_on         = 1'b0;
      hold_left      = 0;
      hold_seen      = 1'b0;
      hold_req       = 1'b0;
      send_idle_pct  = 0;
      rsp_stall_pct  = 0;
      quiet          = 0;
      errors         = 0;
      for (int i = 0; i < 8; i++)
         chain_h[i] = SM3_IV[i];
      for (int i = 0; i < 16; i++)
         block_w[i] = '0;
      block_bytes = 0;
      length_bits = '0;

      repeat (8) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: empty message (padding only)
      queue_msg(0, 3'd0, FILL_ZERO, 1'b0);
      // single final word with byte counts 1 to 7, oversized ones included
      for (int nb = 1; nb <= 7; nb++)
         queue_msg(0, 3'(nb), (nb % 2) ? FILL_ONES : FILL_ZERO, 1'b0);
      // 56 bytes with odd counts on the body: length spills into a second block
      queue_msg(14, 3'd0, FILL_RANDOM, 1'b1);
      drain();

      // Random traffic under each idle/stall pattern
      run_phase(0, 0, 70);
      run_phase(83, 0, 70);
      run_phase(0, 83, 70);
      run_phase(28, 28, 70);

      // Back-pressure: receiver holds off while the driver keeps offering
      send_idle_pct = 0;
      rsp_stall_pct = 0;
      queue_random(30);
      hold_req = 1'b1;
      drain();

      repeat (DRAIN_CYCLES) @(posedge clock);
      if (errors == 0 && digest_due.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
